>>> src/hct_pkg.sv
// Package for the history counter table: field widths, operation codes,
// result and status structs, and the result clamp helper.
// No dependencies.
package hct_pkg;

   // Default table geometry and counter width.
   localparam int PIECE_COUNT_DEF  = 16;
   localparam int SQUARE_COUNT_DEF = 64;
   localparam int COUNT_BITS_DEF   = 16;

   // Fixed field widths of the request and response items.
   localparam int FUNC_W     = 2;
   localparam int PIECE_W    = 4;
   localparam int SQUARE_W   = 6;
   localparam int DEPTH_W    = 8;
   localparam int VALUE_W    = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // Operation codes carried in the func field.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_INC   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_AGE   = 2'd2,
      FUNC_CLEAR = 2'd3
   } hct_func_type;

   // One result item.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               aged;
   } hct_result_type;

   // Status of the output stage as seen by the controller.
   typedef struct packed {
      logic pend_busy;   // a result waits in the pending slot
      logic pend_free;   // the pending slot can take a result this cycle
   } hct_out_status_type;

   // Saturate a counter value to the 16-bit result field.
   function automatic logic [VALUE_W-1:0] hct_clamp16(input logic [31:0] v);
      return (v > 32'h0000_FFFF) ? 16'hFFFF : v[VALUE_W-1:0];
   endfunction

endpackage

>>> src/hct_mem.sv
// Counter storage of the history table: one write port and one read port,
// read data registered. Depends on nothing else.
module hct_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/hct_out.sv
// Output stage of the history table: a pending slot followed by the
// response register, so a finished result never blocks the controller.
// Depends on hct_pkg.
module hct_out
   import hct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hct_result_type        load_data,
   output hct_out_status_type    status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // [15:0] value, [16] aged, rest zero
);

   logic           pend_valid_ff, pend_valid_in;
   hct_result_type pend_data_ff, pend_data_in;
   logic           rsp_valid_ff, rsp_valid_in;
   hct_result_type rsp_data_ff, rsp_data_in;
   logic           move;

   // The pending result moves on when the response register is empty or drains.
   assign move = pend_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (move) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = pend_data_ff;
         pend_valid_in = 1'b0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         pend_valid_in = 1'b1;
         pend_data_in  = load_data;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign status.pend_busy = pend_valid_ff;
   assign status.pend_free = !pend_valid_ff || move;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = {{(RSP_DATA_W-VALUE_W-1){1'b0}}, rsp_data_ff.aged,
                              rsp_data_ff.value};

endmodule

>>> src/history_counter_table_with_aging.sv
// Top level of the history counter table with aging: request decode,
// the controller that runs read-modify-write and table sweeps, and the
// instances of hct_mem and hct_out. Depends on hct_pkg.
//
//   channel | direction | transfer contents (tdata, lowest bit first)
//   req_    | in        | func[1:0] piece[5:2] square[11:6] depth[19:12]
//   rsp_    | out       | value[15:0] aged[16]
//
// Increment and read: the accept cycle issues the memory read, and in the
// next cycle a read returns the value and an increment adds and writes back.
// Age sweeps the table after the accept cycle, halving every entry, and so
// does an increment that overflows, after its add; clear follows the accept
// cycle by zeroing the table, one entry a cycle.
// After reset a clearing pass over all PIECE_COUNT*SQUARE_COUNT entries (1024 by
// default) runs with req_tready low. One result can sit in the response
// register and one in the pending slot; beyond that the input stalls.
module history_counter_table_with_aging
   import hct_pkg::*;
#(
   parameter int PIECE_COUNT  = PIECE_COUNT_DEF,
   parameter int SQUARE_COUNT = SQUARE_COUNT_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [1:0] func, [5:2] piece,
                                              // [11:6] square, [19:12] depth
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [15:0] value, [16] aged
);

   localparam int ENTRIES = PIECE_COUNT * SQUARE_COUNT;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int SH_W    = $clog2(COUNT_BITS);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_RMW   = 4'b0100,
      S_AGE   = 4'b1000
   } hct_state_type;

   hct_state_type      state_ff, state_in;
   hct_func_type       func_ff, func_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [SH_W-1:0]    sh_ff, sh_in;
   logic [CNT_W-1:0]   sweep_ff, sweep_in;
   logic               ovr_ff, ovr_in;
   logic [COUNT_BITS-1:0] ovr_val_ff, ovr_val_in;

   hct_func_type       req_func;
   logic [PIECE_W-1:0] req_piece;
   logic [SQUARE_W-1:0] req_square;
   logic [DEPTH_W-1:0] req_depth;
   logic [31:0]        idx_wide;
   logic [ADDR_W-1:0]  req_idx;
   logic               req_addr_ok;
   logic [SH_W-1:0]    req_sh;
   logic               accept;

   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [COUNT_BITS-1:0] mem_rd_data;
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [COUNT_BITS-1:0] mem_wr_data;
   logic [CNT_W-1:0]      sweep_m1;

   logic [COUNT_BITS:0]   inc;
   logic [COUNT_BITS:0]   sum;

   logic               out_load;
   hct_result_type     out_data;
   hct_out_status_type out_status;

   // Request field decode and table index.
   assign req_func    = hct_func_type'(req_tdata[1:0]);
   assign req_piece   = req_tdata[5:2];
   assign req_square  = req_tdata[11:6];
   assign req_depth   = req_tdata[19:12];
   assign idx_wide    = 32'(req_piece) * 32'(SQUARE_COUNT) + 32'(req_square);
   assign req_idx     = idx_wide[ADDR_W-1:0];
   assign req_addr_ok = (32'(req_piece) < 32'(PIECE_COUNT)) &&
                        (32'(req_square) < 32'(SQUARE_COUNT));
   assign req_sh      = (req_depth < DEPTH_W'(COUNT_BITS - 1)) ? SH_W'(req_depth)
                                                               : SH_W'(COUNT_BITS - 1);

   assign req_tready = (state_ff == S_IDLE) && out_status.pend_free;
   assign accept     = req_tvalid && req_tready;

   // Increment arithmetic, one bit wider to see the overflow.
   assign inc      = (COUNT_BITS + 1)'(1) << sh_ff;
   assign sum      = {1'b0, mem_rd_data} + inc;
   assign sweep_m1 = sweep_ff - CNT_W'(1);

   // Controller: decode, read-modify-write and the clear and age sweeps.
   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      idx_in      = idx_ff;
      sh_in       = sh_ff;
      sweep_in    = sweep_ff;
      ovr_in      = ovr_ff;
      ovr_val_in  = ovr_val_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = req_idx;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = '0;
      out_load    = 1'b0;
      out_data    = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff[ADDR_W-1:0];
            sweep_in    = sweep_ff + CNT_W'(1);
            if (sweep_ff == CNT_W'(ENTRIES - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               idx_in   = req_idx;
               sh_in    = req_sh;
               sweep_in = '0;
               case (req_func)
                  FUNC_INC, FUNC_READ: begin
                     if (req_addr_ok) begin
                        mem_rd_en = 1'b1;
                        state_in  = S_RMW;
                     end else begin
                        out_load = 1'b1;
                     end
                  end
                  FUNC_AGE: begin
                     out_load      = 1'b1;
                     out_data.aged = 1'b1;
                     ovr_in        = 1'b0;
                     state_in      = S_AGE;
                  end
                  FUNC_CLEAR: begin
                     out_load = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RMW: begin
            out_load = 1'b1;
            if (func_ff == FUNC_READ) begin
               out_data.value = hct_clamp16(32'(mem_rd_data));
               state_in       = S_IDLE;
            end else if (sum[COUNT_BITS]) begin
               // Overflow: the entry takes the halved sum during the age sweep.
               ovr_in         = 1'b1;
               ovr_val_in     = sum[COUNT_BITS:1];
               out_data.value = hct_clamp16(32'(sum[COUNT_BITS:1]));
               out_data.aged  = 1'b1;
               sweep_in       = '0;
               state_in       = S_AGE;
            end else begin
               mem_wr_en      = 1'b1;
               mem_wr_data    = sum[COUNT_BITS-1:0];
               out_data.value = hct_clamp16(32'(sum[COUNT_BITS-1:0]));
               state_in       = S_IDLE;
            end
         end
         S_AGE: begin
            // Read entry n while entry n-1 is written back halved.
            mem_rd_en   = sweep_ff < CNT_W'(ENTRIES);
            mem_rd_addr = sweep_ff[ADDR_W-1:0];
            mem_wr_en   = sweep_ff != '0;
            mem_wr_addr = sweep_m1[ADDR_W-1:0];
            mem_wr_data = (ovr_ff && (sweep_m1[ADDR_W-1:0] == idx_ff)) ? ovr_val_ff
                                                                        : mem_rd_data >> 1;
            sweep_in    = sweep_ff + CNT_W'(1);
            if (sweep_ff == CNT_W'(ENTRIES)) begin
               sweep_in = '0;
               ovr_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sweep_ff <= '0;
         ovr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         ovr_ff   <= ovr_in;
      end
   end

   // Item payload held for the operation in progress.
   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      idx_ff     <= idx_in;
      sh_ff      <= sh_in;
      ovr_val_ff <= ovr_val_in;
   end

   hct_mem #(
      .DEPTH (ENTRIES),
      .WIDTH (COUNT_BITS)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   hct_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .load_data  (out_data),
      .status     (out_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTH
   // The pending slot is empty whenever a read-modify-write finishes.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RMW) |-> !out_status.pend_busy)
      else $error("pending result slot busy during read-modify-write");

   // The sweep never writes the entry it reads in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("memory read and write collide on one entry");

   // An accepted age command starts the age sweep.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_AGE)) |=> (state_ff == S_AGE))
      else $error("age command did not start the sweep");

   // The overflow override lives only during an age sweep.
   assert property (@(posedge clock) disable iff (reset)
      ovr_ff |-> (state_ff == S_AGE))
      else $error("overflow override outside the age sweep");
`endif

endmodule

>>> verif/hct_checker.sv
// Checker for the history counter table: watches the request and response
// streams, predicts every result from its own copy of the table and compares.
// Depends on hct_pkg.
module hct_checker
   import hct_pkg::*;
#(
   parameter int PIECE_COUNT  = PIECE_COUNT_DEF,
   parameter int SQUARE_COUNT = SQUARE_COUNT_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [1:0] func, [5:2] piece,
                                              // [11:6] square, [19:12] depth
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] value, [16] aged
   output int                    fail_count,
   output int                    awaited_count,
   output int                    inc_count,
   output int                    read_count,
   output int                    age_count,
   output int                    clear_count,
   output int                    overflow_count
);

   localparam int ENTRIES   = PIECE_COUNT * SQUARE_COUNT;
   localparam int MAX_SHIFT = COUNT_BITS - 1;
   localparam int MAX_SHOWN = 10;

   // Bit offsets of the request fields.
   localparam int PIECE_LO  = FUNC_W;
   localparam int SQUARE_LO = PIECE_LO + PIECE_W;
   localparam int DEPTH_LO  = SQUARE_LO + SQUARE_W;

   longint unsigned score_table [ENTRIES];
   hct_result_type  expected_results [$];
   int              fails;
   int              results_seen;

   // Halve every counter, rounding down.
   function automatic void halve_scores();
      foreach (score_table[i]) score_table[i] = score_table[i] >> 1;
   endfunction

   // Apply one request to the predicted table and return its result.
   function automatic hct_result_type score_update(input hct_func_type func,
                                                   input logic [PIECE_W-1:0] piece,
                                                   input logic [SQUARE_W-1:0] square,
                                                   input logic [DEPTH_W-1:0] depth);
      hct_result_type  res;
      bit              in_range;
      int              idx;
      int              shift;
      longint unsigned level;
      res.value = '0;
      res.aged  = 1'b0;
      level     = 0;
      in_range  = (int'(piece) < PIECE_COUNT) && (int'(square) < SQUARE_COUNT);
      idx       = in_range ? int'(piece) * SQUARE_COUNT + int'(square) : 0;
      case (func)
         FUNC_INC: begin
            inc_count++;
            if (in_range) begin
               shift = (int'(depth) < MAX_SHIFT) ? int'(depth) : MAX_SHIFT;
               score_table[idx] += longint'(1) << shift;
               if (score_table[idx] >= (longint'(1) << COUNT_BITS)) begin
                  halve_scores();
                  res.aged = 1'b1;
                  overflow_count++;
               end
               level = score_table[idx];
            end
         end
         FUNC_READ: begin
            read_count++;
            if (in_range) level = score_table[idx];
         end
         FUNC_AGE: begin
            age_count++;
            halve_scores();
            res.aged = 1'b1;
         end
         default: begin
            clear_count++;
            foreach (score_table[i]) score_table[i] = 0;
         end
      endcase
      // The result field saturates for wide counters.
      res.value = (level > 64'hFFFF) ? 16'hFFFF : level[VALUE_W-1:0];
      return res;
   endfunction

   initial begin
      foreach (score_table[i]) score_table[i] = 0;
      fails          = 0;
      results_seen   = 0;
      fail_count     = 0;
      awaited_count  = 0;
      inc_count      = 0;
      read_count     = 0;
      age_count      = 0;
      clear_count    = 0;
      overflow_count = 0;
   end

   // Compare each result transfer first, then predict the new request, so a
   // result can never match an expectation queued in the same cycle.
   always @(posedge clock) begin
      hct_result_type exp_res;
      hct_result_type got_res;
      if (reset) begin
         foreach (score_table[i]) score_table[i] = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_res.value = rsp_tdata[VALUE_W-1:0];
            got_res.aged  = rsp_tdata[VALUE_W];
            results_seen++;
            if (expected_results.size() == 0) begin
               fails++;
               if (fails <= MAX_SHOWN)
                  $display("result %0d arrived with no request waiting: value %h aged %b",
                           results_seen, got_res.value, got_res.aged);
            end else begin
               exp_res = expected_results.pop_front();
               if (got_res.value !== exp_res.value || got_res.aged !== exp_res.aged) begin
                  fails++;
                  if (fails <= MAX_SHOWN)
                     $display("result %0d mismatch: value exp %h got %h, aged exp %b got %b",
                              results_seen, exp_res.value, got_res.value,
                              exp_res.aged, got_res.aged);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(score_update(
               hct_func_type'(req_tdata[FUNC_W-1:0]),
               req_tdata[PIECE_LO +: PIECE_W],
               req_tdata[SQUARE_LO +: SQUARE_W],
               req_tdata[DEPTH_LO +: DEPTH_W]));
      end
      fail_count    <= fails;
      awaited_count <= expected_results.size();
   end

endmodule

>>> verif/tb_top.sv
// Top of the history counter table testbench: clock, reset, request and
// response stimulus with random stalls, and the final verdict.
// Depends on hct_pkg, history_counter_table_with_aging and hct_checker.
module tb_top
   import hct_pkg::*;
;

   // Even if every item swept the whole table, the roughly 530 items with stalls
   // stay well under this bound.
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_WAIT  = 1100;
   localparam int HOT_SLOTS   = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count;
   int awaited_count;
   int inc_count;
   int read_count;
   int age_count;
   int clear_count;
   int overflow_count;

   int   cycle_count;
   bit   idle_on;
   logic hold_req;
   logic [PIECE_W-1:0]  hot_piece  [HOT_SLOTS];
   logic [SQUARE_W-1:0] hot_square [HOT_SLOTS];

   history_counter_table_with_aging u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hct_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .fail_count     (fail_count),
      .awaited_count  (awaited_count),
      .inc_count      (inc_count),
      .read_count     (read_count),
      .age_count      (age_count),
      .clear_count    (clear_count),
      .overflow_count (overflow_count)
   );

   // Clock with a period of 20.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the total run length.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response side: random stalls after transfers when idle_on is set, and a long hold-off
   // on request so that the block fills up and stalls its input.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      hold_req   = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req   <= 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rsp_tready && rsp_tvalid) begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
         end else if (!rsp_tready && !reset) begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Pack the request fields, lowest field first.
   function automatic logic [REQ_DATA_W-1:0] pack_req(input hct_func_type func,
                                                      input logic [PIECE_W-1:0] piece,
                                                      input logic [SQUARE_W-1:0] square,
                                                      input logic [DEPTH_W-1:0] depth);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[FUNC_W-1:0]                          = func;
      word[FUNC_W +: PIECE_W]                   = piece;
      word[FUNC_W+PIECE_W +: SQUARE_W]          = square;
      word[FUNC_W+PIECE_W+SQUARE_W +: DEPTH_W]  = depth;
      return word;
   endfunction

   // Offer one request and wait for its transfer; valid stays high into the
   // next request unless a gap is drawn.
   task automatic send_req(input hct_func_type func, input logic [PIECE_W-1:0] piece,
                           input logic [SQUARE_W-1:0] square,
                           input logic [DEPTH_W-1:0] depth);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_req(func, piece, square, depth);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Random traffic, mostly on a few hot entries so that counters overflow.
   task automatic run_random(input int count, input bit with_idle);
      int           pick;
      int           slot;
      hct_func_type func;
      logic [PIECE_W-1:0]  piece;
      logic [SQUARE_W-1:0] square;
      logic [DEPTH_W-1:0]  depth;
      idle_on = with_idle;
      foreach (hot_piece[i]) begin
         hot_piece[i]  = PIECE_W'($urandom_range(0, (1 << PIECE_W) - 1));
         hot_square[i] = SQUARE_W'($urandom_range(0, (1 << SQUARE_W) - 1));
      end
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 58)      func = FUNC_INC;
         else if (pick < 94) func = FUNC_READ;
         else if (pick < 98) func = FUNC_AGE;
         else                func = FUNC_CLEAR;
         if ($urandom_range(0, 99) < 70) begin
            slot   = $urandom_range(0, HOT_SLOTS - 1);
            piece  = hot_piece[slot];
            square = hot_square[slot];
         end else begin
            piece  = PIECE_W'($urandom_range(0, (1 << PIECE_W) - 1));
            square = SQUARE_W'($urandom_range(0, (1 << SQUARE_W) - 1));
         end
         pick = $urandom_range(0, 99);
         if (pick < 50)      depth = DEPTH_W'($urandom_range(10, 15));
         else if (pick < 60) depth = DEPTH_W'($urandom_range(16, 255));
         else                depth = DEPTH_W'($urandom_range(0, 255));
         send_req(func, piece, square, depth);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      idle_on    = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: corner entries, the depth clamp, overflow by more
      // than and exactly to the top, age and clear commands.
      send_req(FUNC_READ,   4'd0,  6'd0,   8'd0);
      send_req(FUNC_INC,    4'd0,  6'd0,   8'd0);
      send_req(FUNC_INC,    4'd0,  6'd0,   8'd255);
      send_req(FUNC_INC,    4'd15, 6'd63,  8'd14);
      send_req(FUNC_INC,    4'd15, 6'd63,  8'd15);
      send_req(FUNC_READ,   4'd15, 6'd63,  8'd0);
      send_req(FUNC_INC,    4'd15, 6'd63,  8'd16);
      send_req(FUNC_READ,   4'd0,  6'd0,   8'd0);
      send_req(FUNC_INC,    4'd3,  6'd5,   8'd15);
      send_req(FUNC_INC,    4'd3,  6'd5,   8'd15);
      send_req(FUNC_AGE,    4'd7,  6'd9,   8'd200);
      send_req(FUNC_READ,   4'd15, 6'd63,  8'd0);
      send_req(FUNC_INC,    4'd15, 6'd0,   8'd1);
      send_req(FUNC_INC,    4'd0,  6'd63,  8'd7);
      send_req(FUNC_READ,   4'd15, 6'd0,   8'd0);
      send_req(FUNC_CLEAR,  4'd15, 6'd63,  8'd255);
      send_req(FUNC_READ,   4'd15, 6'd63,  8'd0);
      send_req(FUNC_READ,   4'd0,  6'd0,   8'd0);
      send_req(FUNC_INC,    4'd10, 6'd42,  8'd128);
      send_req(FUNC_AGE,    4'd0,  6'd0,   8'd0);
      send_req(FUNC_AGE,    4'd0,  6'd0,   8'd0);
      send_req(FUNC_READ,   4'd10, 6'd42,  8'd0);

      // Random phases, with and without stalls, and one long hold-off.
      run_random(120, 1'b1);
      run_random(100, 1'b0);
      hold_req <= 1'b1;
      run_random(24, 1'b0);
      run_random(130, 1'b1);
      run_random(130, 1'b1);
      req_tvalid <= 1'b0;

      // Drain, then give the block time to show any stray result.
      do @(posedge clock); while (awaited_count != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d increments (%0d with table overflow), %0d reads, %0d ages, %0d clears.",
               inc_count, overflow_count, read_count, age_count, clear_count);
      $display("Traffic used hot entries, random stalls on both streams and a long output hold-off.");
      if (fail_count == 0 && awaited_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
src/hct_pkg.sv
src/hct_mem.sv
src/hct_out.sv
src/history_counter_table_with_aging.sv
verif/hct_checker.sv
verif/tb_top.sv
